### sv/sle_pkg.sv
`default_nettype none

package sle_pkg;

    localparam int LINE_CAPACITY_DEF = 63;

    localparam logic [7:0] CODE_BACKSPACE = 8'h0E;
    localparam logic [7:0] CODE_ENTER     = 8'h1C;
    localparam logic [7:0] CODE_LSHIFT    = 8'h2A;
    localparam logic [7:0] RELEASE_BIT    = 8'h80;
    localparam logic [7:0] TABLE_TOP      = 8'd57;
    localparam logic [6:0] CASE_OFFSET    = 7'h20;

    typedef enum logic [2:0] {
        KIND_ECHO      = 3'd0,
        KIND_ERASE     = 3'd1,
        KIND_LINE_CHAR = 3'd2,
        KIND_LINE_END  = 3'd3,
        KIND_FULL      = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        CLS_SHIFT_ON,
        CLS_SHIFT_OFF,
        CLS_IGNORE,
        CLS_BACKSPACE,
        CLS_ENTER,
        CLS_CHAR
    } code_class_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_READ,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        CHSEL_ZERO,
        CHSEL_MAPPED,
        CHSEL_STORE
    } char_sel_t;

    typedef struct packed {
        logic      load_code;
        logic      set_shift;
        logic      clr_shift;
        logic      dec_len;
        logic      store_char;
        logic      clr_len;
        logic      idx_clr;
        logic      idx_inc;
        logic      ram_rd;
        logic      rd_next;
        logic      out_load;
        kind_t     out_kind;
        char_sel_t out_sel;
        logic      out_last;
    } sle_cmd_t;

    typedef struct packed {
        code_class_t cls;
        logic        len_zero;
        logic        len_full;
        logic        idx_at_len;
        logic        next_in_line;
        logic        out_free;
    } sle_stat_t;

    // US qwerty set-1 map for codes 0..57; unmapped keys give '?'.
    function automatic logic [6:0] map_us(input logic [5:0] code);
        logic [6:0] ch;
        unique case (code)
            6'd2:  ch = 7'h31;
            6'd3:  ch = 7'h32;
            6'd4:  ch = 7'h33;
            6'd5:  ch = 7'h34;
            6'd6:  ch = 7'h35;
            6'd7:  ch = 7'h36;
            6'd8:  ch = 7'h37;
            6'd9:  ch = 7'h38;
            6'd10: ch = 7'h39;
            6'd11: ch = 7'h30;
            6'd12: ch = 7'h2D;
            6'd13: ch = 7'h3D;
            6'd16: ch = 7'h71;
            6'd17: ch = 7'h77;
            6'd18: ch = 7'h65;
            6'd19: ch = 7'h72;
            6'd20: ch = 7'h74;
            6'd21: ch = 7'h79;
            6'd22: ch = 7'h75;
            6'd23: ch = 7'h69;
            6'd24: ch = 7'h6F;
            6'd25: ch = 7'h70;
            6'd26: ch = 7'h5B;
            6'd27: ch = 7'h5D;
            6'd30: ch = 7'h61;
            6'd31: ch = 7'h73;
            6'd32: ch = 7'h64;
            6'd33: ch = 7'h66;
            6'd34: ch = 7'h67;
            6'd35: ch = 7'h68;
            6'd36: ch = 7'h6A;
            6'd37: ch = 7'h6B;
            6'd38: ch = 7'h6C;
            6'd39: ch = 7'h3B;
            6'd40: ch = 7'h27;
            6'd41: ch = 7'h60;
            6'd43: ch = 7'h5C;
            6'd44: ch = 7'h7A;
            6'd45: ch = 7'h78;
            6'd46: ch = 7'h63;
            6'd47: ch = 7'h76;
            6'd48: ch = 7'h62;
            6'd49: ch = 7'h6E;
            6'd50: ch = 7'h6D;
            6'd51: ch = 7'h2C;
            6'd52: ch = 7'h2E;
            6'd53: ch = 7'h2F;
            6'd57: ch = 7'h20;
            default: ch = 7'h3F;
        endcase
        return ch;
    endfunction

    // The FR azerty map differs from the US one on seven keys only.
    function automatic logic [6:0] map_char(input logic fr, input logic [5:0] code);
        logic [6:0] ch;
        ch = map_us(code);
        if (fr) begin
            unique case (code)
                6'd16:   ch = 7'h61;
                6'd17:   ch = 7'h7A;
                6'd30:   ch = 7'h71;
                6'd39:   ch = 7'h6D;
                6'd44:   ch = 7'h77;
                6'd50:   ch = 7'h2C;
                6'd51:   ch = 7'h3B;
                default: ch = ch;
            endcase
        end
        return ch;
    endfunction

endpackage

`default_nettype wire

### sv/scancode_line_editor.sv
`default_nettype none

// Line editor driven by set-1 keyboard scancodes.
// Input channel (s_valid/s_ready/s_scancode): one scancode byte per transfer.
// Result channel (m_valid/m_ready/m_kind/m_character/m_last): zero or more
// results per scancode; m_last marks the final result of a scancode.
// Configuration: cfg_we writes cfg_wdata into the layout select (0 US, 1 FR).
// An ordinary key, backspace on a non-empty line or full-line drop gives one
// result, loaded into the result register once it is free; only then is the
// block ready again. Shift, ignored codes and an empty-line backspace give none.
// Enter on a line of n characters streams n line characters and a line end;
// the line store has one read port, and the controller fetches the next
// character from it while the current one goes out.
// Reset (synchronous, active low) empties the line, releases shift and
// selects the FR layout; stored characters are not cleared since only
// entries below the line length are ever read.
// The results leave through an output register: when the receiver holds
// m_ready low, the result waits there and the controller stalls at its
// next result, while a new scancode may already be taken in.
module scancode_line_editor
    import sle_pkg::*;
#(
    parameter int LINE_CAPACITY = LINE_CAPACITY_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_scancode,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [2:0]      m_kind,
    output logic [6:0]      m_character,
    output logic            m_last,
    input  wire logic       cfg_we,
    input  wire logic       cfg_wdata
);

    // Commands from the controller and status back from the datapath.
    sle_cmd_t  cmd;
    sle_stat_t stat;

    sle_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // The datapath holds the scancode, shift and layout flags, line length,
    // read index, the line store and the result register.
    sle_dp #(
        .LINE_CAPACITY (LINE_CAPACITY)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_scancode  (s_scancode),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .m_ready     (m_ready),
        .m_valid     (m_valid),
        .m_kind      (m_kind),
        .m_character (m_character),
        .m_last      (m_last),
        .cmd         (cmd),
        .stat        (stat)
    );

endmodule

`default_nettype wire

### sv/sle_ram.sv
`default_nettype none

module sle_ram #(
    parameter int WIDTH = 7,
    parameter int DEPTH = 63,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### sv/sle_ctrl.sv
`default_nettype none

module sle_ctrl
    import sle_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire sle_stat_t stat,
    output sle_cmd_t       cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.out_kind = KIND_ECHO;
        cmd.out_sel  = CHSEL_ZERO;
        s_ready      = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready       = 1'b1;
                cmd.load_code = s_valid;
                if (s_valid) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                unique case (stat.cls)
                    CLS_SHIFT_ON: begin
                        cmd.set_shift = 1'b1;
                        state_next    = ST_IDLE;
                    end
                    CLS_SHIFT_OFF: begin
                        cmd.clr_shift = 1'b1;
                        state_next    = ST_IDLE;
                    end
                    CLS_BACKSPACE: begin
                        if (stat.len_zero) begin
                            state_next = ST_IDLE;
                        end else if (stat.out_free) begin
                            cmd.dec_len  = 1'b1;
                            cmd.out_load = 1'b1;
                            cmd.out_kind = KIND_ERASE;
                            cmd.out_last = 1'b1;
                            state_next   = ST_IDLE;
                        end
                    end
                    CLS_ENTER: begin
                        cmd.idx_clr = 1'b1;
                        state_next  = ST_READ;
                    end
                    CLS_CHAR: begin
                        if (stat.out_free) begin
                            cmd.out_load = 1'b1;
                            cmd.out_last = 1'b1;
                            if (stat.len_full) begin
                                cmd.out_kind = KIND_FULL;
                            end else begin
                                cmd.store_char = 1'b1;
                                cmd.out_kind   = KIND_ECHO;
                                cmd.out_sel    = CHSEL_MAPPED;
                            end
                            state_next = ST_IDLE;
                        end
                    end
                    default: begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_READ: begin
                if (stat.idx_at_len) begin
                    if (stat.out_free) begin
                        cmd.out_load = 1'b1;
                        cmd.out_kind = KIND_LINE_END;
                        cmd.out_last = 1'b1;
                        cmd.clr_len  = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end else begin
                    cmd.ram_rd = 1'b1;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = KIND_LINE_CHAR;
                    cmd.out_sel  = CHSEL_STORE;
                    cmd.idx_inc  = 1'b1;
                    if (stat.next_in_line) begin
                        // Fetch the following character while this one goes out.
                        cmd.ram_rd  = 1'b1;
                        cmd.rd_next = 1'b1;
                    end else begin
                        state_next = ST_READ;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### sv/sle_dp.sv
`default_nettype none

module sle_dp
    import sle_pkg::*;
#(
    parameter int LINE_CAPACITY = LINE_CAPACITY_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic [7:0] s_scancode,
    input  wire logic       cfg_we,
    input  wire logic       cfg_wdata,
    input  wire logic       m_ready,
    output logic            m_valid,
    output logic [2:0]      m_kind,
    output logic [6:0]      m_character,
    output logic            m_last,
    input  wire sle_cmd_t   cmd,
    output sle_stat_t       stat
);

    localparam int LEN_W  = $clog2(LINE_CAPACITY + 1);
    localparam int ADDR_W = (LINE_CAPACITY > 1) ? $clog2(LINE_CAPACITY) : 1;

    logic [7:0]       code_reg;
    logic             shift_reg;
    logic             layout_reg;
    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] idx_reg;
    logic             m_valid_reg;
    kind_t            kind_reg;
    logic [6:0]       char_reg;
    logic             last_reg;

    logic [LEN_W-1:0]  idx_plus;
    logic [6:0]        mapped;
    logic [6:0]        ram_rdata;
    logic [ADDR_W-1:0] rd_addr;
    logic [6:0]        char_next;
    code_class_t       cls;

    // Shift codes win over the range check; 0x2A sits inside the table range.
    always_comb begin
        if (code_reg == CODE_LSHIFT) begin
            cls = CLS_SHIFT_ON;
        end else if (code_reg == (CODE_LSHIFT | RELEASE_BIT)) begin
            cls = CLS_SHIFT_OFF;
        end else if (code_reg > TABLE_TOP) begin
            cls = CLS_IGNORE;
        end else if (code_reg == CODE_BACKSPACE) begin
            cls = CLS_BACKSPACE;
        end else if (code_reg == CODE_ENTER) begin
            cls = CLS_ENTER;
        end else begin
            cls = CLS_CHAR;
        end
    end

    always_comb begin
        mapped = map_char(layout_reg, code_reg[5:0]);
        if (shift_reg && mapped >= 7'h61 && mapped <= 7'h7A) begin
            mapped = mapped - CASE_OFFSET;
        end
    end

    assign idx_plus = idx_reg + LEN_W'(1);
    assign rd_addr  = cmd.rd_next ? idx_plus[ADDR_W-1:0] : idx_reg[ADDR_W-1:0];

    always_comb begin
        stat.cls          = cls;
        stat.len_zero     = (len_reg == '0);
        stat.len_full     = (len_reg == LEN_W'(LINE_CAPACITY));
        stat.idx_at_len   = (idx_reg == len_reg);
        stat.next_in_line = (idx_plus < len_reg);
        stat.out_free     = !m_valid_reg || m_ready;
    end

    sle_ram #(
        .WIDTH (7),
        .DEPTH (LINE_CAPACITY)
    ) u_line_ram (
        .aclk  (aclk),
        .we    (cmd.store_char),
        .waddr (len_reg[ADDR_W-1:0]),
        .wdata (mapped),
        .re    (cmd.ram_rd),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    always_comb begin
        case (cmd.out_sel)
            CHSEL_MAPPED: char_next = mapped;
            CHSEL_STORE:  char_next = ram_rdata;
            default:      char_next = 7'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_reg   <= 1'b0;
            layout_reg  <= 1'b1;
            len_reg     <= '0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                layout_reg <= cfg_wdata;
            end
            if (cmd.set_shift) begin
                shift_reg <= 1'b1;
            end else if (cmd.clr_shift) begin
                shift_reg <= 1'b0;
            end
            if (cmd.clr_len) begin
                len_reg <= '0;
            end else if (cmd.dec_len) begin
                len_reg <= len_reg - LEN_W'(1);
            end else if (cmd.store_char) begin
                len_reg <= len_reg + LEN_W'(1);
            end
            if (cmd.idx_clr) begin
                idx_reg <= '0;
            end else if (cmd.idx_inc) begin
                idx_reg <= idx_plus;
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_code) begin
            code_reg <= s_scancode;
        end
        if (cmd.out_load) begin
            kind_reg <= cmd.out_kind;
            char_reg <= char_next;
            last_reg <= cmd.out_last;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_kind      = kind_reg;
    assign m_character = char_reg;
    assign m_last      = last_reg;

endmodule

`default_nettype wire

### sv/sle_checker.sv
`default_nettype none

module sle_checker
    import sle_pkg::*;
(
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [2:0] m_kind,
    input wire logic [6:0] m_character,
    input wire logic       m_last
);

    // A stalled result holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_kind) && $stable(m_character)
            && $stable(m_last))
        else $error("result changed while stalled");

    a_kind_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_kind <= KIND_FULL)
        else $error("result kind out of range");

    // Only a line character is followed by more results of the same scancode.
    a_last_line_char: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == KIND_LINE_CHAR |-> !m_last)
        else $error("line character marked last");

    a_last_other: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind != KIND_LINE_CHAR |-> m_last)
        else $error("single result not marked last");

    a_char_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind != KIND_ECHO && m_kind != KIND_LINE_CHAR |-> m_character == 7'd0)
        else $error("character not zero for a non-character result");

endmodule

bind scancode_line_editor sle_checker u_sle_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_kind      (m_kind),
    .m_character (m_character),
    .m_last      (m_last)
);

`default_nettype wire
